### src/assert_macros.svh
// assertion helpers for the matrix engine, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/smma_pkg.sv
package smma_pkg;

    localparam int OP_W      = 3;
    localparam int IDX_W     = 4;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 48;
    localparam int CFG_W     = 5;
    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A    = 3'd0,
        OP_WRITE_B    = 3'd1,
        OP_ACCUMULATE = 3'd2,
        OP_READ_C     = 3'd3,
        OP_CLEAR_C    = 3'd4
    } smma_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_MAC,
        ST_DRAIN
    } smma_state_t;

    // control from the sequencer to the multiply-add unit
    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctrl_t;

endpackage

### src/smma_if.sv
interface smma_req_if;
    import smma_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, opcode, row_index, col_index, element_value, input ready);
    modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface smma_rsp_if;
    import smma_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] read_value;
    logic                    status;
    logic                    saturated;

    modport source (output valid, read_value, status, saturated, input ready);
    modport sink (input valid, read_value, status, saturated, output ready);
endinterface

interface smma_cfg_if;
    import smma_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] size_in_use;

    modport source (output valid, size_in_use, input ready);
    modport sink (input valid, size_in_use, output ready);
endinterface

### src/smma_mac.sv
module smma_mac #(
    parameter int DOT_W = 37
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smma_pkg::mac_ctrl_t                ctrl,
    input  logic signed [smma_pkg::ELEM_W-1:0] a_data,
    input  logic signed [smma_pkg::ELEM_W-1:0] b_data,
    output logic signed [DOT_W-1:0]            dot,
    output logic                               busy
);
    import smma_pkg::*;

    logic                     s1_vld_reg;
    logic                     s2_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [DOT_W-1:0]  dot_next;

    // operands arrive in the cycle after issue (registered memory read)
    assign prod_next = a_data * b_data;

    always_comb
    begin
        dot_next = dot_reg;
        if (ctrl.clear)
        begin
            dot_next = '0;
        end
        else if (s2_vld_reg)
        begin
            dot_next = dot_reg + DOT_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            dot_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= ctrl.issue;
            s2_vld_reg <= s1_vld_reg;
            dot_reg    <= dot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign dot  = dot_reg;
    assign busy = s1_vld_reg | s2_vld_reg;

endmodule

### src/square_matrix_multiply_accumulate_core.sv
// write a/b, out-of-range and unused opcodes answer directly from idle; read c answers
// via a read state; clear c sweeps MAX_DIM*MAX_DIM entries; accumulate walks m*m elements
// throughput: one transaction in flight; the single shared multiply-add unit
// walks m products per c element, then drains the pipe and updates c
// reset: size_in_use returns to 16 and c is zeroed by a sweep of all MAX_DIM*MAX_DIM
// entries during which no request is taken (config writes still are)
`include "assert_macros.svh"

module square_matrix_multiply_accumulate_core #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    smma_req_if.sink    req,
    smma_rsp_if.source  rsp,
    smma_cfg_if.sink    cfg
);
    import smma_pkg::*;

    // storage geometry
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EFF_W  = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
    // dot product width: one full product plus growth over at most MAX_DIM terms
    localparam int DOT_W  = PROD_W + CNT_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // sequencer state and loop counters
    smma_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               sat_reg, sat_next;
    logic [CFG_W-1:0]   size_reg;

    // result register
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic signed [ACC_W-1:0] read_value_reg;
    logic                    status_reg;
    logic                    saturated_reg;
    logic                    rsp_load;
    logic signed [ACC_W-1:0] read_value_next;
    logic                    status_next;
    logic                    saturated_next;

    // memories
    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [ACC_W-1:0]  mem_c [DEPTH];
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;
    logic signed [ACC_W-1:0]  c_rd_reg;
    logic                     a_we;
    logic                     b_we;
    logic                     c_we;
    logic signed [ACC_W-1:0]  c_wr_data;
    logic [ADDR_W-1:0]        req_addr;
    logic [ADDR_W-1:0]        ij_addr;
    logic [ADDR_W-1:0]        a_rd_addr;
    logic [ADDR_W-1:0]        b_rd_addr;
    logic [ADDR_W-1:0]        c_rd_addr;
    logic [ADDR_W-1:0]        c_wr_addr;

    // shared multiply-add unit
    mac_ctrl_t               mac_ctrl;
    logic signed [DOT_W-1:0] dot;
    logic                    mac_busy;

    // decode helpers
    logic             req_fire;
    logic             req_ready;
    logic [EFF_W-1:0] eff;
    logic [EFF_W-1:0] eff_last;
    logic             in_range;
    logic             k_last;
    logic             j_last;
    logic             i_last;
    logic signed [ACC_W:0] sum_wide;
    logic             sum_ovf;
    logic signed [ACC_W-1:0] sum_sat;

    // effective size m = min(size_in_use, MAX_DIM)
    assign eff      = (EFF_W'(size_reg) > EFF_W'(MAX_DIM)) ? EFF_W'(MAX_DIM) : EFF_W'(size_reg);
    assign eff_last = eff - EFF_W'(1);
    assign in_range = (EFF_W'(req.row_index) < eff) && (EFF_W'(req.col_index) < eff);
    assign k_last   = (EFF_W'(k_reg) == eff_last);
    assign j_last   = (EFF_W'(j_reg) == eff_last);
    assign i_last   = (EFF_W'(i_reg) == eff_last);

    // row-major addressing
    assign req_addr  = ADDR_W'(int'(req.row_index) * MAX_DIM + int'(req.col_index));
    assign ij_addr   = ADDR_W'(int'(i_reg) * MAX_DIM + int'(j_reg));
    assign a_rd_addr = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign b_rd_addr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));
    assign c_rd_addr = (state_reg == ST_IDLE) ? req_addr : ij_addr;
    assign c_wr_addr = (state_reg == ST_INIT || state_reg == ST_CLEAR) ? clr_addr_reg : ij_addr;

    // c update: old value plus dot, clamped to the 48-bit range
    assign sum_wide = (ACC_W + 1)'(c_rd_reg) + (ACC_W + 1)'(dot);
    assign sum_ovf  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
    always_comb
    begin
        if (!sum_ovf)
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
        else if (sum_wide[ACC_W])
        begin
            sum_sat = {1'b1, {(ACC_W - 1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(ACC_W - 1){1'b1}}};
        end
    end

    // a new request only when idle and the result slot is free or draining
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req.ready = req_ready;
    assign req_fire  = req.valid && req_ready;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.opcode)
                        OP_READ_C:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_ACCUMULATE:
                        begin
                            if (eff != '0)
                            begin
                                state_next = ST_MAC;
                            end
                        end
                        OP_CLEAR_C:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_MAC:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // pipe empty: c element is written this cycle
                if (!mac_busy)
                begin
                    state_next = (i_last && j_last) ? ST_IDLE : ST_MAC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath control
    always_comb
    begin
        a_we            = 1'b0;
        b_we            = 1'b0;
        c_we            = 1'b0;
        c_wr_data       = '0;
        mac_ctrl        = '0;
        rsp_load        = 1'b0;
        read_value_next = '0;
        status_next     = 1'b0;
        saturated_next  = 1'b0;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        clr_addr_next   = clr_addr_reg;
        sat_next        = sat_reg;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                c_we          = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                // the reset sweep gives no result, the clear transaction does
                if (clr_addr_reg == LAST_ADDR && state_reg == ST_CLEAR)
                begin
                    rsp_load = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.opcode)
                        OP_WRITE_A:
                        begin
                            a_we        = in_range;
                            status_next = !in_range;
                            rsp_load    = 1'b1;
                        end
                        OP_WRITE_B:
                        begin
                            b_we        = in_range;
                            status_next = !in_range;
                            rsp_load    = 1'b1;
                        end
                        OP_READ_C:
                        begin
                            status_next = 1'b1;
                            rsp_load    = !in_range;
                        end
                        OP_ACCUMULATE:
                        begin
                            i_next         = '0;
                            j_next         = '0;
                            k_next         = '0;
                            sat_next       = 1'b0;
                            mac_ctrl.clear = 1'b1;
                            // empty matrix: nothing to walk
                            rsp_load       = (eff == '0);
                        end
                        OP_CLEAR_C:
                        begin
                            clr_addr_next = '0;
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                read_value_next = c_rd_reg;
                rsp_load        = 1'b1;
            end
            ST_MAC:
            begin
                mac_ctrl.issue = 1'b1;
                k_next         = k_last ? '0 : k_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    c_we           = 1'b1;
                    c_wr_data      = sum_sat;
                    sat_next       = sat_reg | sum_ovf;
                    mac_ctrl.clear = 1'b1;
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + CNT_W'(1);
                        if (i_last)
                        begin
                            saturated_next = sat_reg | sum_ovf;
                            rsp_load       = 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            clr_addr_reg  <= '0;
            sat_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            size_reg      <= SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            clr_addr_reg  <= clr_addr_next;
            sat_reg       <= sat_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                size_reg <= cfg.size_in_use;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
            saturated_reg  <= saturated_next;
        end
    end

    // a and b stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[req_addr] <= req.element_value;
        end
        a_rd_reg <= mem_a[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[req_addr] <= req.element_value;
        end
        b_rd_reg <= mem_b[b_rd_addr];
    end

    // c store: cleared by sweep, updated once per element
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            mem_c[c_wr_addr] <= c_wr_data;
        end
        c_rd_reg <= mem_c[c_rd_addr];
    end

    smma_mac #(
        .DOT_W (DOT_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rd_reg),
        .b_data (b_rd_reg),
        .dot    (dot),
        .busy   (mac_busy)
    );

    assign cfg.ready      = 1'b1;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.saturated  = saturated_reg;

    // a request is only taken when its result has a free slot
    `ASSERT_IMPLIES(a_req_slot_free, req.ready, !rsp_valid_reg || rsp.ready)
    // every transaction either answers at once or keeps the sequencer busy
    `ASSERT_NEXT(a_req_progress, req.valid && req.ready, rsp.valid || state_reg != ST_IDLE)
    // the inner index stays below the effective size while products issue
    `ASSERT_IMPLIES(a_k_bound, state_reg == ST_MAC, EFF_W'(k_reg) < eff)

endmodule
